[sv/assert_macros.svh]
// Assertion helpers used by the top-level RTL. Each macro samples on the rising
// edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HCBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbp assertion failed");
`define HCBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbp assertion failed");
`else
`define HCBP_ASSERT_IMP(lbl, ante, cons)
`define HCBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/hcbp_pkg.sv]
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYM_W        = 8;
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 32;
    localparam int ACC_W        = 7;
    localparam int FILL_W       = 3;
    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W      = LEN_W + CODE_W;
    // effective length cap: the configured maximum, never above the code width
    localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_FULL    = 2'd0,
        ST_PARTIAL = 2'd1,
        ST_NOCODE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } ex_t;

endpackage

[sv/hcbp_ram.sv]
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/hcbp_table.sv]
module hcbp_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic                           rd_en,
    input  logic [hcbp_pkg::SYM_W-1:0]     sym,
    input  logic [hcbp_pkg::LEN_W-1:0]     wr_len,
    input  logic [hcbp_pkg::CODE_W-1:0]    wr_code,
    output hcbp_pkg::entry_t               entry
);

    logic [hcbp_pkg::ADDR_W-1:0]  addr;
    logic                         in_range;
    logic [hcbp_pkg::LEN_W-1:0]   clen;
    logic [hcbp_pkg::CODE_W-1:0]  code_mask;
    hcbp_pkg::entry_t             wr_entry;
    hcbp_pkg::entry_t             rd_entry;
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] valid_reg;
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] valid_next;
    logic                         hit_reg;
    logic                         hit_next;

    assign addr     = sym[hcbp_pkg::ADDR_W-1:0];
    assign in_range = ({1'b0, sym} < (hcbp_pkg::SYM_W+1)'(hcbp_pkg::SYMBOL_COUNT));

    // saturate the length, clear code bits above it
    always_comb
    begin
        clen = (wr_len > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP))
             ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP) : wr_len;
        code_mask = hcbp_pkg::CODE_W'(((hcbp_pkg::CODE_W+1)'(1) << clen)
                                      - (hcbp_pkg::CODE_W+1)'(1));
        wr_entry.len  = clen;
        wr_entry.code = wr_code & code_mask;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en && in_range)
        begin
            valid_next[addr] = 1'b1;
        end
        hit_next = hit_reg;
        if (rd_en)
        begin
            hit_next = valid_reg[addr] && in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_W),
        .DEPTH (hcbp_pkg::SYMBOL_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en && in_range),
        .wr_addr (addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_entry)
    );

    // an entry never loaded reads as length zero
    always_comb
    begin
        entry.len  = hit_reg ? rd_entry.len : '0;
        entry.code = rd_entry.code;
    end

endmodule

[sv/hcbp_pack.sv]
module hcbp_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcbp_pkg::ex_t                 ex,
    input  hcbp_pkg::entry_t              entry,
    input  logic                          out_ready,
    output logic                          advance,
    output logic                          out_valid,
    output logic [hcbp_pkg::BYTE_W-1:0]   packed_byte,
    output logic [1:0]                    status,
    output logic [2:0]                    pad_bits,
    output logic                          last
);

    localparam int COMB_W = hcbp_pkg::CODE_W + hcbp_pkg::ACC_W;
    localparam int LA_W   = hcbp_pkg::CODE_W + hcbp_pkg::BYTE_W;

    logic [hcbp_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [hcbp_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [hcbp_pkg::CODE_W-1:0] em_buf_reg, em_buf_next;
    logic [2:0]                  em_cnt_reg, em_cnt_next;
    hcbp_pkg::status_t           em_status_reg, em_status_next;
    logic [2:0]                  em_pad_reg, em_pad_next;

    logic                        is_err;
    logic [COMB_W-1:0]           comb_r;
    logic [hcbp_pkg::LEN_W-1:0]  total;
    logic [2:0]                  nbytes;
    logic [2:0]                  rem;
    logic [LA_W-1:0]             la;
    logic [hcbp_pkg::ACC_W-1:0]  rem_mask;
    logic [2:0]                  flush_sh;
    logic [hcbp_pkg::BYTE_W-1:0] flush_byte;
    logic [2:0]                  res_cnt;
    logic                        em_free;
    logic                        out_fire;

    always_comb
    begin
        is_err   = (entry.len == '0);
        comb_r   = ({{hcbp_pkg::CODE_W{1'b0}}, acc_reg} << entry.len)
                 | {{hcbp_pkg::ACC_W{1'b0}}, entry.code};
        total    = hcbp_pkg::LEN_W'(fill_reg) + entry.len;
        nbytes   = total[5:3];
        rem      = total[2:0];
        // left-align the pending bits so completed bytes sit at the top
        la       = {1'b0, comb_r} << (hcbp_pkg::LEN_W'(LA_W) - total);
        rem_mask = hcbp_pkg::ACC_W'((8'd1 << rem) - 8'd1);
        flush_sh   = 3'd0 - fill_reg;
        flush_byte = {1'b0, acc_reg} << flush_sh;

        case (ex.op)
            hcbp_pkg::OP_ENCODE: res_cnt = is_err ? 3'd1 : nbytes;
            hcbp_pkg::OP_FLUSH:  res_cnt = (fill_reg != '0) ? 3'd1 : 3'd0;
            default:             res_cnt = 3'd0;
        endcase
    end

    assign out_valid = (em_cnt_reg != 3'd0);
    assign out_fire  = out_valid && out_ready;
    assign em_free   = (em_cnt_reg == 3'd0) || ((em_cnt_reg == 3'd1) && out_ready);
    assign advance   = ex.valid && ((res_cnt == 3'd0) || em_free);

    always_comb
    begin
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        em_buf_next    = em_buf_reg;
        em_cnt_next    = em_cnt_reg;
        em_status_next = em_status_reg;
        em_pad_next    = em_pad_reg;

        if (out_fire)
        begin
            em_buf_next = em_buf_reg << hcbp_pkg::BYTE_W;
            em_cnt_next = em_cnt_reg - 3'd1;
        end

        if (advance)
        begin
            case (ex.op)
                hcbp_pkg::OP_ENCODE:
                begin
                    if (is_err)
                    begin
                        em_buf_next    = '0;
                        em_status_next = hcbp_pkg::ST_NOCODE;
                        em_pad_next    = 3'd0;
                    end
                    else
                    begin
                        acc_next       = comb_r[hcbp_pkg::ACC_W-1:0] & rem_mask;
                        fill_next      = rem;
                        em_buf_next    = la[LA_W-1 -: hcbp_pkg::CODE_W];
                        em_status_next = hcbp_pkg::ST_FULL;
                        em_pad_next    = 3'd0;
                    end
                    if (res_cnt != 3'd0)
                    begin
                        em_cnt_next = res_cnt;
                    end
                    else
                    begin
                        // no completed byte: keep the emitter as it drains
                        em_buf_next    = out_fire ? (em_buf_reg << hcbp_pkg::BYTE_W)
                                                  : em_buf_reg;
                        em_status_next = em_status_reg;
                        em_pad_next    = em_pad_reg;
                    end
                end
                hcbp_pkg::OP_FLUSH:
                begin
                    if (fill_reg != '0)
                    begin
                        em_buf_next    = {flush_byte, {(hcbp_pkg::CODE_W-hcbp_pkg::BYTE_W){1'b0}}};
                        em_cnt_next    = 3'd1;
                        em_status_next = hcbp_pkg::ST_PARTIAL;
                        em_pad_next    = flush_sh;
                        acc_next       = '0;
                        fill_next      = '0;
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fill_reg      <= '0;
            em_cnt_reg    <= 3'd0;
            em_status_reg <= hcbp_pkg::ST_FULL;
            em_pad_reg    <= 3'd0;
        end
        else
        begin
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            em_cnt_reg    <= em_cnt_next;
            em_status_reg <= em_status_next;
            em_pad_reg    <= em_pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_buf_reg <= em_buf_next;
    end

    assign packed_byte = em_buf_reg[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W];
    assign status      = em_status_reg;
    assign pad_bits    = em_pad_reg;
    assign last        = (em_cnt_reg == 3'd1);

endmodule

[sv/huffman_code_bit_packer.sv]
// An encode or flush item's first result is registered in the output stage as it leaves
// the execute stage. Throughput: one item per cycle while each yields at most one byte and
// out_ready is high; longer items hold the single output register (up to 4 bytes per item).
// The code table is one 256 x 38 synchronous RAM with one read and one write port.
// Reset (rst_n, async, active low) clears all valid bits, so every table entry reads as
// "no code", and empties the bit accumulator and the output stage. No clearing pass.
`include "assert_macros.svh"

module huffman_code_bit_packer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  logic [hcbp_pkg::LEN_W-1:0]    code_len,
    input  logic [hcbp_pkg::CODE_W-1:0]   code_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]   packed_byte,
    output logic [1:0]                    status,
    output logic [2:0]                    pad_bits,
    output logic                          last
);

    // Pipeline:
    //   accept   - load items write the table right away; encode items launch
    //              the table read; encode and flush items enter the execute stage.
    //   execute  - the read data is valid here; merge the code with the pending
    //              bits, update the accumulator and hand finished bytes to the
    //              output register. Stall only when a result is due and the output
    //              register is still busy.
    //   output   - a small byte queue (up to 4 bytes) that hands out its bytes in order.
    // A load right before an encode of the same symbol is safe: the write lands
    // at the load's accept edge, the read at the encode's own, later accept edge.

    hcbp_pkg::ex_t    ex_reg, ex_next;
    hcbp_pkg::entry_t entry;
    logic             accept;
    logic             advance;
    logic             is_load;
    logic             is_encode;
    logic             is_flush;

    assign is_load   = (op == hcbp_pkg::OP_LOAD);
    assign is_encode = (op == hcbp_pkg::OP_ENCODE);
    assign is_flush  = (op == hcbp_pkg::OP_FLUSH);

    // take a new item whenever the execute stage is empty or leaving
    assign in_ready = !ex_reg.valid || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ex_next = ex_reg;
        if (advance)
        begin
            ex_next.valid = 1'b0;
        end
        if (accept && (is_encode || is_flush))
        begin
            ex_next.valid = 1'b1;
            ex_next.op    = hcbp_pkg::op_t'(op);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_reg.valid <= 1'b0;
            ex_reg.op    <= hcbp_pkg::OP_LOAD;
        end
        else
        begin
            ex_reg <= ex_next;
        end
    end

    hcbp_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && is_load),
        .rd_en   (accept && is_encode),
        .sym     (symbol),
        .wr_len  (code_len),
        .wr_code (code_word),
        .entry   (entry)
    );

    hcbp_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .ex          (ex_reg),
        .entry       (entry),
        .out_ready   (out_ready),
        .advance     (advance),
        .out_valid   (out_valid),
        .packed_byte (packed_byte),
        .status      (status),
        .pad_bits    (pad_bits),
        .last        (last)
    );

    // an accepted encode or flush must be in the execute stage next cycle
    `HCBP_ASSERT_NEXT(a_ex_enter, accept && (is_encode || is_flush), ex_reg.valid)
    // a stalled execute stage holds its item
    `HCBP_ASSERT_NEXT(a_ex_hold, ex_reg.valid && !advance, ex_reg.valid && $stable(ex_reg.op))
    // flushed and error results are always single and final
    `HCBP_ASSERT_IMP(a_single_last, out_valid && (status != hcbp_pkg::ST_FULL), last)
    // a flushed byte always carries at least one pad bit
    `HCBP_ASSERT_IMP(a_flush_pad, out_valid && (status == hcbp_pkg::ST_PARTIAL), pad_bits != 3'd0)

endmodule

[bench/tb_huffman_code_bit_packer.sv]
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer;
    import hcbp_pkg::*;

    // Op value 3 has no meaning; the block must drop it without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Several times the slowest correct run, even with four results per item
    // and the longest stalls on both sides.
    localparam int CYCLE_LIMIT = 400000;

    // One result as the output channel presents it.
    typedef struct {
        logic [BYTE_W-1:0] data;
        status_t           st;
        logic [2:0]        pad;
        logic              last;
    } packed_result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_len;
    logic [CODE_W-1:0] code_word;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] packed_byte;
    logic [1:0]        status;
    logic [2:0]        pad_bits;
    logic              last;

    // Shadow of the block's state: code table plus pending bit stash.
    logic [LEN_W-1:0]  tbl_len [SYMBOL_COUNT];
    logic [CODE_W-1:0] tbl_code [SYMBOL_COUNT];
    logic [ACC_W-1:0]  pend_bits;
    int                pend_fill;

    // Bytes and status results still owed by the block, oldest first.
    packed_result_t byte_queue[$];

    bit idle_en;        // allow random gaps on the input and stalls on the output
    int hold_cycles;    // long output hold-off, counted down by the receiver
    int stall_left;
    int cycle_count;
    int fail_count;
    int mismatch_count;
    int n_load, n_encode, n_flush, n_unused;
    int n_full, n_partial, n_nocode;

    huffman_code_bit_packer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .symbol      (symbol),
        .code_len    (code_len),
        .code_word   (code_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .packed_byte (packed_byte),
        .status      (status),
        .pad_bits    (pad_bits),
        .last        (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, byte_queue.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle length, drawn from three ranges: mostly the shortest, now and then a long stretch.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    // Code length for a load: mostly short codes, some empty, some at or past the cap.
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 75)
            return LEN_W'($urandom_range(1, 10));
        else if (r < 88)
            return LEN_W'($urandom_range(11, 31));
        else if (r < 95)
            return LEN_W'(LEN_CAP);
        return LEN_W'($urandom_range(LEN_CAP + 1, 63));
    endfunction

    function automatic logic [63:0] low_ones(int n);
        return (64'd1 << n) - 64'd1;
    endfunction

    // Work out the results one accepted item causes and advance the shadow state.
    function automatic void predict_packing(logic [1:0] op_v, logic [SYM_W-1:0] sym_v,
                                            logic [LEN_W-1:0] len_v,
                                            logic [CODE_W-1:0] word_v);
        int             len;
        int             total;
        int             produced;
        logic [63:0]    acc;
        packed_result_t res;
        case (op_v)
            OP_LOAD:
            begin
                // Saturate overlong lengths and clear code bits above the length.
                len = (int'(len_v) > LEN_CAP) ? LEN_CAP : int'(len_v);
                tbl_len[sym_v] = LEN_W'(len);
                tbl_code[sym_v] = word_v & CODE_W'(low_ones(len));
            end
            OP_ENCODE:
            begin
                len = int'(tbl_len[sym_v]);
                if (len == 0)
                begin
                    // No code: report it, leave the pending bits alone.
                    res = '{data: '0, st: ST_NOCODE, pad: '0, last: 1'b1};
                    byte_queue.push_back(res);
                end
                else
                begin
                    acc = (64'(pend_bits) << len) | 64'(tbl_code[sym_v]);
                    total = pend_fill + len;
                    produced = 0;
                    while (total >= 8)
                    begin
                        res = '{data: BYTE_W'(acc >> (total - 8)), st: ST_FULL,
                                pad: '0, last: 1'b0};
                        byte_queue.push_back(res);
                        produced++;
                        total -= 8;
                    end
                    pend_bits = ACC_W'(acc & low_ones(total));
                    pend_fill = total;
                    if (produced > 0)
                        byte_queue[byte_queue.size() - 1].last = 1'b1;
                end
            end
            OP_FLUSH:
            begin
                // Empty stash flushes to nothing.
                if (pend_fill != 0)
                begin
                    res = '{data: BYTE_W'({1'b0, pend_bits} << (8 - pend_fill)),
                            st: ST_PARTIAL, pad: 3'(8 - pend_fill), last: 1'b1};
                    byte_queue.push_back(res);
                    pend_bits = '0;
                    pend_fill = 0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one item and hold it until accepted. Called at a rising edge; leaves
    // in_valid high so that a following item can go out in the next cycle.
    task automatic send_item(input logic [1:0] op_v, input logic [SYM_W-1:0] sym_v,
                             input logic [LEN_W-1:0] len_v,
                             input logic [CODE_W-1:0] word_v);
        int gap;
        gap = (idle_en && $urandom_range(0, 1) == 1) ? pick_idle() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= op_v;
        symbol    <= sym_v;
        code_len  <= len_v;
        code_word <= word_v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_packing(op_v, sym_v, len_v, word_v);
        case (op_v)
            OP_LOAD:   n_load++;
            OP_ENCODE: n_encode++;
            OP_FLUSH:  n_flush++;
            default:   n_unused++;
        endcase
    endtask

    // One random item of a well-formed stream: mostly encodes of coded symbols,
    // with loads, flushes, stray symbols and unused ops mixed in.
    task automatic send_random_item();
        logic [SYM_W-1:0] sym;
        int               r;
        int               tries;
        r = $urandom_range(0, 99);
        sym = SYM_W'($urandom());
        if (r < 12)
            send_item(OP_LOAD, sym, pick_len(), $urandom());
        else if (r < 80)
        begin
            // Prefer a symbol that has a code; give up now and then.
            tries = 0;
            while (tbl_len[sym] == 0 && tries < 8 && $urandom_range(0, 9) != 0)
            begin
                sym = SYM_W'($urandom());
                tries++;
            end
            send_item(OP_ENCODE, sym, LEN_W'($urandom()), $urandom());
        end
        else if (r < 95)
            send_item(OP_FLUSH, sym, LEN_W'($urandom()), $urandom());
        else
            send_item(OP_UNUSED, sym, LEN_W'($urandom()), $urandom());
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = pick_idle() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (byte_queue.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result byte=%02h status=%0d pad=%0d last=%0b",
                             $realtime, packed_byte, status, pad_bits, last);
            end
            else
            begin
                packed_result_t want;
                want = byte_queue.pop_front();
                case (want.st)
                    ST_FULL:    n_full++;
                    ST_PARTIAL: n_partial++;
                    default:    n_nocode++;
                endcase
                if (packed_byte !== want.data || status !== want.st
                    || pad_bits !== want.pad || last !== want.last)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch exp byte=%02h status=%0d pad=%0d last=%0b",
                                 $realtime, want.data, want.st, want.pad, want.last);
                        $display("    got byte=%02h status=%0d pad=%0d last=%0b",
                                 packed_byte, status, pad_bits, last);
                    end
                end
            end
        end
    end

    // Hand-picked items: empty table, length extremes, masking, padding,
    // symbols without code with bits pending, and table entries removed again.
    task automatic test_directed();
        send_item(OP_ENCODE, 8'h00, 6'h00, 32'h0000_0000);  // entry never loaded
        send_item(OP_FLUSH,  8'h00, 6'h00, 32'h0000_0000);  // nothing pending
        send_item(OP_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        send_item(OP_LOAD,   8'hFF, 6'd32, 32'hFFFF_FFFF);  // longest legal code
        send_item(OP_ENCODE, 8'hFF, 6'h00, 32'h0000_0000);  // four bytes at once
        send_item(OP_LOAD,   8'h01, 6'h3F, 32'hA5A5_A5A5);  // saturates to the cap
        send_item(OP_ENCODE, 8'h01, 6'h3F, 32'hFFFF_FFFF);
        send_item(OP_LOAD,   8'h02, 6'd1,  32'hFFFF_FFFE);  // upper bits dropped
        send_item(OP_ENCODE, 8'h02, 6'h00, 32'h0000_0000);
        send_item(OP_LOAD,   8'h03, 6'd7,  32'h0000_007F);
        send_item(OP_ENCODE, 8'h03, 6'h00, 32'h0000_0000);  // completes a byte
        send_item(OP_ENCODE, 8'h02, 6'h00, 32'h0000_0000);
        send_item(OP_FLUSH,  8'h00, 6'h00, 32'h0000_0000);  // seven pad bits
        send_item(OP_LOAD,   8'h04, 6'd5,  32'h0000_0015);
        send_item(OP_ENCODE, 8'h04, 6'h00, 32'h0000_0000);  // load then encode back to back
        send_item(OP_ENCODE, 8'h04, 6'h00, 32'h0000_0000);
        send_item(OP_FLUSH,  8'hFF, 6'h3F, 32'hFFFF_FFFF);
        send_item(OP_LOAD,   8'h00, 6'd0,  32'hFFFF_FFFF);  // zero length stays uncoded
        send_item(OP_ENCODE, 8'h03, 6'h00, 32'h0000_0000);
        send_item(OP_ENCODE, 8'h00, 6'h00, 32'h0000_0000);  // no code, seven bits pending
        send_item(OP_FLUSH,  8'h00, 6'h00, 32'h0000_0000);  // one pad bit
        send_item(OP_LOAD,   8'h03, 6'd0,  32'h0000_0000);  // remove a code
        send_item(OP_ENCODE, 8'h03, 6'h00, 32'h0000_0000);
    endtask

    // Random stream with idling on both sides.
    task automatic test_random_stream();
        idle_en = 1'b1;
        for (int i = 0; i < 24; i++)
            send_item(OP_LOAD, SYM_W'($urandom()), LEN_W'($urandom_range(1, 14)), $urandom());
        for (int i = 0; i < 236; i++)
            send_random_item();
    endtask

    // Same stream shape with no gaps and no stalls.
    task automatic test_back_to_back();
        idle_en = 1'b0;
        for (int i = 0; i < 40; i++)
            send_random_item();
    endtask

    // Hold the output off for a long stretch while long codes keep coming in,
    // so the block fills up and drops in_ready.
    task automatic test_output_hold();
        idle_en = 1'b0;
        for (int s = 0; s < 4; s++)
            send_item(OP_LOAD, SYM_W'(8'hA0 + s), LEN_W'($urandom_range(24, LEN_CAP)),
                      $urandom());
        hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            send_item(OP_ENCODE, SYM_W'(8'hA0 + $urandom_range(0, 3)), '0, $urandom());
        send_item(OP_FLUSH, '0, '0, '0);
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_LOAD;
        symbol    = '0;
        code_len  = '0;
        code_word = '0;
        idle_en   = 1'b0;
        hold_cycles = 0;
        pend_bits = '0;
        pend_fill = 0;
        for (int s = 0; s < SYMBOL_COUNT; s++)
        begin
            tbl_len[s]  = '0;
            tbl_code[s] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream();
        test_back_to_back();
        test_output_hold();

        // Drain: wait for every owed result, then give stragglers time to show.
        in_valid <= 1'b0;
        while (byte_queue.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Sent %0d loads, %0d encodes, %0d flushes, %0d unused ops.",
                 n_load, n_encode, n_flush, n_unused);
        $display("Checked %0d full bytes, %0d flushed bytes, %0d no-code results; %0d bad.",
                 n_full, n_partial, n_nocode, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[huffman_code_bit_packer.f]
+incdir+sv
sv/hcbp_pkg.sv
sv/hcbp_ram.sv
sv/hcbp_table.sv
sv/hcbp_pack.sv
sv/huffman_code_bit_packer.sv
bench/tb_huffman_code_bit_packer.sv
